/* src/ped_pkg.sv */
// Shared constants, codes and types of the palette error-diffusion dither.
`default_nettype none

package ped_pkg;

   // Longest supported row in pixels; the error line RAM holds one word per column.
   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

   localparam int CHANNELS = 3;
   localparam int ERR_W    = 12;
   localparam int NEAR_AW  = 12;
   localparam int PAL_AW   = 8;
   localparam int COLOR_W  = 24;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Action codes carried in the low bits of req_tuser.
   localparam logic [1:0] ACT_PIXEL = 2'd0;
   localparam logic [1:0] ACT_NEAR  = 2'd1;
   localparam logic [1:0] ACT_PAL   = 2'd2;
   localparam logic [1:0] ACT_RSVD  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DITHER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREY   = 1'b1;

   // What the back end has to do with a queued beat.
   typedef enum logic [2:0] {
      K_PLAIN,
      K_DGREY,
      K_DRGB,
      K_WNEAR,
      K_WPAL
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic                 first;
      logic [COL_W-1:0]     column;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [NEAR_AW-1:0]   addr;
      logic [COLOR_W-1:0]   data;
   } entry_type;

   typedef struct packed {
      logic clearing;
   } status_type;

endpackage

`default_nettype wire

/* src/ped_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ped_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/ped_front.sv */
// Input side: accepts beats, tracks the column, classifies each beat for the back end.
`default_nettype none

module ped_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ped_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [ped_pkg::REQ_USER_W-1:0]      req_tuser,
   input  wire logic                                csr_we,
   input  wire logic [ped_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ped_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire ped_pkg::status_type                 back_status,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output ped_pkg::entry_type                       q_entry
);

   logic                      dither_ff, dither_in;
   logic                      grey_ff, grey_in;
   logic [ped_pkg::COL_W-1:0] column_ff, column_in;

   logic                      accept;
   logic [1:0]                action;
   logic                      first;
   logic [7:0]                red, green, blue;
   logic [ped_pkg::NEAR_AW-1:0] table_addr;
   logic [ped_pkg::COLOR_W-1:0] table_data;
   logic [ped_pkg::COL_W-1:0] col_start;
   logic [ped_pkg::NEAR_AW-1:0] plain_idx;
   ped_pkg::kind_type         kind;

   assign action     = req_tuser[1:0];
   assign first      = req_tuser[2];
   assign red        = req_tdata[7:0];
   assign green      = req_tdata[15:8];
   assign blue       = req_tdata[23:16];
   assign table_addr = req_tdata[35:24];
   assign table_data = req_tdata[59:36];

   assign req_tready = !q_full && !back_status.clearing;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && (action != ped_pkg::ACT_RSVD);

   assign col_start = first ? '0 : column_ff;
   assign plain_idx = grey_ff ? {red[7:4], red[7:4], red[7:4]}
                              : {red[7:4], green[7:4], blue[7:4]};

   always_comb begin
      unique case (action)
         ped_pkg::ACT_PIXEL: begin
            if (!dither_ff) begin
               kind = ped_pkg::K_PLAIN;
            end else if (grey_ff) begin
               kind = ped_pkg::K_DGREY;
            end else begin
               kind = ped_pkg::K_DRGB;
            end
         end
         ped_pkg::ACT_NEAR: kind = ped_pkg::K_WNEAR;
         default:           kind = ped_pkg::K_WPAL;
      endcase
   end

   always_comb begin
      q_entry.kind   = kind;
      q_entry.first  = first;
      q_entry.column = col_start;
      q_entry.red    = red;
      q_entry.green  = green;
      q_entry.blue   = blue;
      q_entry.addr   = (kind == ped_pkg::K_PLAIN) ? plain_idx : table_addr;
      q_entry.data   = table_data;
   end

   always_comb begin
      dither_in = dither_ff;
      grey_in   = grey_ff;
      if (csr_we) begin
         unique case (csr_index)
            ped_pkg::CSR_DITHER: dither_in = csr_wdata[0];
            ped_pkg::CSR_GREY:   grey_in   = csr_wdata[0];
         endcase
      end
      column_in = column_ff;
      if (accept && (action == ped_pkg::ACT_PIXEL)) begin
         column_in = (col_start == ped_pkg::LAST_COL) ? '0 : col_start + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= 1'b1;
         grey_ff   <= 1'b0;
         column_ff <= '0;
      end else begin
         dither_ff <= dither_in;
         grey_ff   <= grey_in;
         column_ff <= column_in;
      end
   end

endmodule

`default_nettype wire

/* src/ped_queue.sv */
// Short queue of classified beats between the front and the back end.
`default_nettype none

module ped_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ped_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output logic                     full,
   output logic                     empty,
   output ped_pkg::entry_type       head
);

   ped_pkg::entry_type         slot_ff [ped_pkg::QUEUE_DEPTH];
   logic [ped_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ped_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ped_pkg::QPTR_W:0]   count_ff, count_in;

   localparam logic [ped_pkg::QPTR_W-1:0] LAST_SLOT =
      ped_pkg::QPTR_W'(ped_pkg::QUEUE_DEPTH - 1);

   assign full  = (count_ff == (ped_pkg::QPTR_W + 1)'(ped_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* src/ped_back.sv */
// Back end: table loads, lookups, error diffusion over the error line RAM, result buffer.
`default_nettype none

module ped_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_empty,
   input  wire ped_pkg::entry_type             q_head,
   output logic                                q_pop,
   output ped_pkg::status_type                 status,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [ped_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int CH     = ped_pkg::CHANNELS;
   localparam int EW     = ped_pkg::ERR_W;
   localparam int WORD_W = CH * EW;
   localparam int OUT_DEPTH = 2;
   localparam logic [EW-1:0] ERR_MAX_C = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] ERR_MIN_C = {1'b1, {(EW-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ERR0,
      ST_LOOK,
      ST_PAL,
      ST_WR0,
      ST_WR1
   } state_type;

   // Saturate a 14-bit two's complement value to the 12-bit error range.
   function automatic logic [EW-1:0] sat12(input logic [13:0] v);
      logic [EW-1:0] r;
      if ((v[13:11] == 3'b000) || (v[13:11] == 3'b111)) begin
         r = v[EW-1:0];
      end else if (v[13]) begin
         r = ERR_MIN_C;
      end else begin
         r = ERR_MAX_C;
      end
      return r;
   endfunction

   state_type                  state_ff, state_in;
   logic [ped_pkg::COL_W-1:0]  clr_ff, clr_in;
   ped_pkg::entry_type         item_ff, item_in;
   logic [WORD_W-1:0]          ec_ff, ec_in;
   logic [WORD_W-1:0]          old1_ff, old1_in;
   logic [WORD_W-1:0]          w1_ff, w1_in;
   logic [12:0]                val_ff [CH];
   logic [12:0]                val_in [CH];
   logic [12:0]                err_ff [CH];
   logic [12:0]                err_in [CH];
   logic [9:0]                 t_ff [CH];
   logic [9:0]                 t_in [CH];
   logic [EW-1:0]              carry_ff [CH];
   logic [EW-1:0]              carry_in [CH];
   logic                       plain_pend_ff, plain_pend_in;
   logic                       promise_ff, promise_in;
   logic [7:0]                 obuf_ff [OUT_DEPTH];
   logic [7:0]                 obuf_in [OUT_DEPTH];
   logic                       ohead_ff, ohead_in;
   logic [1:0]                 ocount_ff, ocount_in;

   logic                        near_we;
   logic [ped_pkg::NEAR_AW-1:0] near_waddr, near_raddr;
   logic [7:0]                  near_wdata, near_rdata;
   logic                        pal_we;
   logic [ped_pkg::PAL_AW-1:0]  pal_waddr, pal_raddr;
   logic [ped_pkg::COLOR_W-1:0] pal_wdata, pal_rdata;
   logic                        err_we;
   logic [ped_pkg::COL_W-1:0]   err_waddr, err_raddr;
   logic [WORD_W-1:0]           err_wdata, err_rdata;

   logic                        grey;
   logic [7:0]                  pix [CH];
   logic [12:0]                 v [CH];
   logic [7:0]                  clampv [CH];
   logic [3:0]                  grey_n;
   logic [ped_pkg::NEAR_AW-1:0] near_idx;
   logic [ped_pkg::COL_W-1:0]   next_col;
   logic [7:0]                  comp [CH];
   logic [12:0]                 errv [CH];
   logic [13:0]                 e3 [CH];
   logic [13:0]                 t14 [CH];
   logic [13:0]                 t3 [CH];
   logic [EW-1:0]               cnew [CH];
   logic [EW-1:0]               w0 [CH];
   logic [EW-1:0]               w1 [CH];
   logic [WORD_W-1:0]           w0_word, w1_word;

   logic                        push, opop, out_space, tail_idx;
   logic [2:0]                  out_load;

   ped_ram #(.WIDTH(8), .DEPTH(1 << ped_pkg::NEAR_AW)) u_near (
      .clock (clock),
      .we    (near_we),
      .waddr (near_waddr),
      .wdata (near_wdata),
      .raddr (near_raddr),
      .rdata (near_rdata)
   );

   ped_ram #(.WIDTH(ped_pkg::COLOR_W), .DEPTH(1 << ped_pkg::PAL_AW)) u_pal (
      .clock (clock),
      .we    (pal_we),
      .waddr (pal_waddr),
      .wdata (pal_wdata),
      .raddr (pal_raddr),
      .rdata (pal_rdata)
   );

   ped_ram #(.WIDTH(WORD_W), .DEPTH(ped_pkg::MAX_WIDTH)) u_err (
      .clock (clock),
      .we    (err_we),
      .waddr (err_waddr),
      .wdata (err_wdata),
      .raddr (err_raddr),
      .rdata (err_rdata)
   );

   assign status.clearing = (state_ff == ST_CLEAR);
   assign grey = (item_ff.kind == ped_pkg::K_DGREY);
   assign pix[0] = item_ff.red;
   assign pix[1] = item_ff.green;
   assign pix[2] = item_ff.blue;
   assign next_col = (item_ff.column == ped_pkg::LAST_COL) ? '0 : item_ff.column + 1'b1;

   // Datapath of the diffusion steps; the state machine picks what is used when.
   always_comb begin
      for (int ch = 0; ch < CH; ch++) begin
         // Pixel plus the stored error of this column, clamped for the colour lookup.
         v[ch] = {5'b0, pix[ch]} + {err_rdata[ch*EW + EW-1], err_rdata[ch*EW +: EW]};
         if (v[ch][12]) begin
            clampv[ch] = 8'h00;
         end else if (v[ch][11:8] != 4'h0) begin
            clampv[ch] = 8'hFF;
         end else begin
            clampv[ch] = v[ch][7:0];
         end
         // Error against the chosen palette colour, and three sixteenths of it.
         comp[ch] = pal_rdata[(CH-1-ch)*8 +: 8];
         errv[ch] = val_ff[ch] - {5'b0, comp[ch]};
         e3[ch]   = {errv[ch][12], errv[ch]} + {errv[ch], 1'b0};
         // Write-back values of the current entry, the next entry and the carry.
         t14[ch]  = {{4{t_ff[ch][9]}}, t_ff[ch]};
         t3[ch]   = t14[ch] + {t14[ch][12:0], 1'b0};
         cnew[ch] = sat12({err_ff[ch][12], err_ff[ch]} - t3[ch]);
         w0[ch]   = sat12({{2{carry_ff[ch][EW-1]}}, carry_ff[ch]} + t14[ch]);
         w1[ch]   = sat12({{2{old1_ff[ch*EW + EW-1]}}, old1_ff[ch*EW +: EW]} + t14[ch]);
         if (grey && (ch != 0)) begin
            w0[ch]   = ec_ff[ch*EW +: EW];
            w1[ch]   = old1_ff[ch*EW +: EW];
            cnew[ch] = carry_ff[ch];
         end
         w0_word[ch*EW +: EW] = w0[ch];
         w1_word[ch*EW +: EW] = w1[ch];
      end
      // Grey level: the index is clamped but the error keeps the raw sum.
      if (v[0][12]) begin
         grey_n = 4'h0;
      end else if (v[0][11:8] != 4'h0) begin
         grey_n = 4'hF;
      end else begin
         grey_n = v[0][7:4];
      end
      near_idx = grey ? {grey_n, grey_n, grey_n}
                      : {clampv[0][7:4], clampv[1][7:4], clampv[2][7:4]};
   end

   // Result buffer credit: a pixel is taken only if its result has a slot.
   assign opop      = rsp_tvalid && rsp_tready;
   assign push      = plain_pend_ff || (state_ff == ST_LOOK);
   assign out_load  = 3'(ocount_ff) + 3'(promise_ff) - 3'(opop);
   assign out_space = (out_load < 3'(OUT_DEPTH));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      item_in       = item_ff;
      ec_in         = ec_ff;
      old1_in       = old1_ff;
      w1_in         = w1_ff;
      val_in        = val_ff;
      err_in        = err_ff;
      t_in          = t_ff;
      carry_in      = carry_ff;
      plain_pend_in = 1'b0;
      promise_in    = push ? 1'b0 : promise_ff;
      q_pop         = 1'b0;
      near_we       = 1'b0;
      near_waddr    = q_head.addr;
      near_wdata    = q_head.data[7:0];
      near_raddr    = q_head.addr;
      pal_we        = 1'b0;
      pal_waddr     = q_head.addr[ped_pkg::PAL_AW-1:0];
      pal_wdata     = q_head.data;
      pal_raddr     = near_rdata;
      err_we        = 1'b0;
      err_waddr     = item_ff.column;
      err_wdata     = w0_word;
      err_raddr     = q_head.column;

      unique case (state_ff)
         ST_CLEAR: begin
            err_we    = 1'b1;
            err_waddr = clr_ff;
            err_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ped_pkg::LAST_COL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               case (q_head.kind)
                  ped_pkg::K_WNEAR: begin
                     q_pop   = 1'b1;
                     near_we = 1'b1;
                  end
                  ped_pkg::K_WPAL: begin
                     q_pop  = 1'b1;
                     pal_we = 1'b1;
                  end
                  ped_pkg::K_PLAIN: begin
                     if (out_space) begin
                        q_pop         = 1'b1;
                        plain_pend_in = 1'b1;
                        promise_in    = 1'b1;
                        if (q_head.first) begin
                           for (int ch = 0; ch < CH; ch++) carry_in[ch] = '0;
                        end
                     end
                  end
                  default: begin
                     if (out_space) begin
                        q_pop      = 1'b1;
                        promise_in = 1'b1;
                        item_in    = q_head;
                        state_in   = ST_ERR0;
                        if (q_head.first) begin
                           for (int ch = 0; ch < CH; ch++) carry_in[ch] = '0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_ERR0: begin
            near_raddr = near_idx;
            err_raddr  = next_col;
            ec_in      = err_rdata;
            for (int ch = 0; ch < CH; ch++) begin
               val_in[ch] = (grey && (ch == 0)) ? v[ch] : {5'b0, clampv[ch]};
            end
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            old1_in  = err_rdata;
            state_in = ST_PAL;
         end
         ST_PAL: begin
            for (int ch = 0; ch < CH; ch++) begin
               err_in[ch] = errv[ch];
               t_in[ch]   = e3[ch][13:4];
            end
            state_in = ST_WR0;
         end
         ST_WR0: begin
            err_we    = 1'b1;
            err_waddr = item_ff.column;
            err_wdata = w0_word;
            w1_in     = w1_word;
            carry_in  = cnew;
            state_in  = ST_WR1;
         end
         ST_WR1: begin
            // The entry past the last column is never read back, so it is not kept.
            err_we    = (item_ff.column != ped_pkg::LAST_COL);
            err_waddr = next_col;
            err_wdata = w1_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign tail_idx   = ohead_ff ^ ocount_ff[0];
   assign rsp_tvalid = (ocount_ff != 2'd0);
   assign rsp_tdata  = obuf_ff[ohead_ff];

   always_comb begin
      obuf_in = obuf_ff;
      if (push) begin
         obuf_in[tail_idx] = near_rdata;
      end
      ohead_in  = ohead_ff ^ opop;
      ocount_in = ocount_ff + 2'(push) - 2'(opop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         plain_pend_ff <= 1'b0;
         promise_ff    <= 1'b0;
         ohead_ff      <= 1'b0;
         ocount_ff     <= 2'd0;
         for (int ch = 0; ch < CH; ch++) carry_ff[ch] <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         plain_pend_ff <= plain_pend_in;
         promise_ff    <= promise_in;
         ohead_ff      <= ohead_in;
         ocount_ff     <= ocount_in;
         carry_ff      <= carry_in;
      end
      item_ff <= item_in;
      ec_ff   <= ec_in;
      old1_ff <= old1_in;
      w1_ff   <= w1_in;
      val_ff  <= val_in;
      err_ff  <= err_in;
      t_ff    <= t_in;
      obuf_ff <= obuf_in;
   end

endmodule

`default_nettype wire

/* src/palette_error_diffusion_dither.sv */
// Top level of the palette error-diffusion dither: front, queue and back end.
// Table loads and plain lookups run at one beat per cycle unless a dithered pixel holds
// the back end or, for lookups, the result buffer is full. A dithered pixel holds the
// back end through error read, nearest-table read, palette read, error step and two
// writes through the one write port of the error RAM. Reset is synchronous; afterwards
// req_tready stays low while the error line RAM is cleared one column per cycle, over
// all MAX_WIDTH (4096) columns.
`default_nettype none

module palette_error_diffusion_dither (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input beats.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // From bit 0: red[7:0], green[15:8], blue[23:16], table_addr[35:24],
   // table_data[59:36], zero fill[63:60].
   input  wire logic [ped_pkg::REQ_DATA_W-1:0]    req_tdata,
   // From bit 0: action[1:0], first_in_row[2].
   input  wire logic [ped_pkg::REQ_USER_W-1:0]    req_tuser,
   // Result beats.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // From bit 0: color_index[7:0].
   output logic [ped_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // Register writes: index 0 dither_enable, index 1 grey_mode.
   input  wire logic                              csr_we,
   input  wire logic [ped_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ped_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // The front end classifies each beat (table load, plain lookup, grey or colour
   // dither) and stamps it with its column, so the back end never tracks rows.
   ped_pkg::entry_type  q_entry;
   ped_pkg::entry_type  q_head;
   ped_pkg::status_type back_status;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;

   ped_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // The queue lets the input keep taking beats while a dithered pixel is at work.
   ped_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // The back end owns the tables, the error line RAM, the row carries and a two-entry
   // result buffer; it only takes a pixel when that pixel's result has a free slot.
   ped_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .status     (back_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* src/ped_checker.sv */
// Port-level checks of the dither block, bound to its top level.
`default_nettype none

module ped_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ped_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // The error lines are cleared after reset, so no beat may be taken right after it.
   a_reset_blocks_input: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input taken during the error line clear");

   a_reset_empties_output: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind palette_error_diffusion_dither ped_checker u_checker (.*);

`default_nettype wire

/* dv/tb.sv */
// Testbench of the palette error-diffusion dither: directed and random beats against a predictor.
`timescale 1ns / 1ps

module tb;

   // Watchdog limit. It only trips on a hang.
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Cycles allowed after the last expected result for beats that produce no result
   // (table loads and the unused action) to leave the queue and the back end.
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BEATS   = 215;
   localparam int ERR_HI        = (1 << (ped_pkg::ERR_W - 1)) - 1;
   localparam int ERR_LO        = -(1 << (ped_pkg::ERR_W - 1));

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ped_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ped_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ped_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [ped_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [ped_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // Traffic shaping. The sender's idle odds are used only by the stimulus process;
   // the receiver's stall odds and the hold-off count belong to the receiver process.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   // Predictor state: both lookup tables, the three error lines, the row carries,
   // the column and the two mode bits.
   logic [7:0]                  near_tbl [0:(1 << ped_pkg::NEAR_AW)-1];
   logic [ped_pkg::COLOR_W-1:0] pal_tbl  [0:(1 << ped_pkg::PAL_AW)-1];
   int                          err_line [0:2][0:ped_pkg::MAX_WIDTH];
   int                          carry    [0:2];
   int                          column    = 0;
   bit                          dither_on = 1'b1;
   bit                          grey_on   = 1'b0;

   // Palette indexes the block still owes us, oldest first.
   logic [7:0]         color_index_q [$];

   palette_error_diffusion_dither dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a run that stops making progress ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver. A pending hold-off keeps tready low until it has counted down; otherwise
   // tready is drawn at random against the current stall odds.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Result checker. Every accepted result beat is matched against the oldest
   // expected palette index.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (color_index_q.size() == 0) begin
            $error("color_index: no result expected, actual %0d", rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== color_index_q[0]) begin
               $error("color_index mismatch: expected %0d, actual %0d",
                      color_index_q[0], rsp_tdata);
               fail_count++;
            end
            void'(color_index_q.pop_front());
         end
      end
   end

   function automatic int sat_err(int v);
      if (v > ERR_HI) return ERR_HI;
      if (v < ERR_LO) return ERR_LO;
      return v;
   endfunction

   function automatic int clamp_pixel(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
   endfunction

   // Spread one channel's quantization error at column c. With t = floor(3*err/16),
   // this column keeps t plus the row carry, the next column gains t, and what is
   // left of the error rides along the row as the new carry. All values saturate.
   function automatic void spread_error(int ch, int c, int err);
      int t;
      t = (3 * err) >>> 4;
      err_line[ch][c]     = sat_err(t + carry[ch]);
      err_line[ch][c + 1] = sat_err(err_line[ch][c + 1] + t);
      carry[ch]           = sat_err(err - 3 * t);
   endfunction

   // Apply one accepted beat to the predictor and queue the palette index it should
   // produce, if it produces one.
   task automatic predict_color_index(logic [1:0] action, logic [7:0] r, g, b,
                                      logic first, logic [ped_pkg::NEAR_AW-1:0] addr,
                                      logic [ped_pkg::COLOR_W-1:0] data);
      int                          c, vr, vg, vb;
      logic [3:0]                  nib;
      logic [ped_pkg::NEAR_AW-1:0] idx;
      logic [7:0]                  color;
      logic [ped_pkg::COLOR_W-1:0] rgb;
      case (action)
         ped_pkg::ACT_NEAR: near_tbl[addr] = data[7:0];
         // Only the low byte of the address selects a palette entry.
         ped_pkg::ACT_PAL: pal_tbl[addr[ped_pkg::PAL_AW-1:0]] = data;
         ped_pkg::ACT_PIXEL: begin
            if (first) begin
               carry  = '{0, 0, 0};
               column = 0;
            end
            if (column >= ped_pkg::MAX_WIDTH) column = 0;
            c = column;
            if (!dither_on) begin
               // Plain lookup leaves the error lines and carries alone.
               idx   = grey_on ? {3{r[7:4]}} : {r[7:4], g[7:4], b[7:4]};
               color = near_tbl[idx];
            end else if (grey_on) begin
               // Grey dither: the sum is not clamped, only the table index is.
               vr = int'(r) + err_line[0][c];
               if (vr < 0) nib = 4'h0;
               else if (vr > 255) nib = 4'hF;
               else nib = vr[7:4];
               color = near_tbl[{3{nib}}];
               rgb   = pal_tbl[color];
               spread_error(0, c, vr - int'(rgb[23:16]));
            end else begin
               // Color dither: each channel sum is clamped before the lookup, and
               // the error is taken from the clamped value.
               vr    = clamp_pixel(int'(r) + err_line[0][c]);
               vg    = clamp_pixel(int'(g) + err_line[1][c]);
               vb    = clamp_pixel(int'(b) + err_line[2][c]);
               color = near_tbl[{vr[7:4], vg[7:4], vb[7:4]}];
               rgb   = pal_tbl[color];
               spread_error(0, c, vr - int'(rgb[23:16]));
               spread_error(1, c, vg - int'(rgb[15:8]));
               spread_error(2, c, vb - int'(rgb[7:0]));
            end
            column = c + 1;
            if (column >= ped_pkg::MAX_WIDTH) column = 0;
            color_index_q.push_back(color);
         end
         default: ;  // The unused action is dropped by the block without a result.
      endcase
   endtask

   // Offer one beat, idling first at the current odds, and hold it until the block
   // takes it. Valid stays high on return so back-to-back beats need no gap.
   task automatic send_beat(logic [1:0] action, logic [7:0] r, g, b, logic first,
                            logic [ped_pkg::NEAR_AW-1:0] addr,
                            logic [ped_pkg::COLOR_W-1:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, data, addr, b, g, r};
      req_tuser  <= {first, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_color_index(action, r, g, b, first, addr, data);
   endtask

   // Pixel beat; the table fields are ignored by the block, so they carry noise.
   task automatic send_pixel(logic [7:0] r, g, b, logic first);
      send_beat(ped_pkg::ACT_PIXEL, r, g, b, first, 12'($urandom), 24'($urandom));
   endtask

   // Load beat with random pixel fields and a random row flag.
   task automatic send_load(logic [1:0] action, logic [ped_pkg::NEAR_AW-1:0] addr,
                            logic [ped_pkg::COLOR_W-1:0] data);
      send_beat(action, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                addr, data);
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Stop offering beats, wait for every owed result, then let any trailing table
   // loads drain so that the block is idle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (color_index_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both mode registers on consecutive cycles. Call only when the block is idle.
   task automatic apply_mode(bit dither, bit grey);
      csr_we    <= 1'b1;
      csr_index <= ped_pkg::CSR_DITHER;
      csr_wdata <= dither;
      @(posedge clock);
      dither_on = dither;
      csr_index <= ped_pkg::CSR_GREY;
      csr_wdata <= grey;
      @(posedge clock);
      grey_on = grey;
      csr_we  <= 1'b0;
   endtask

   // Both tables are undefined until written, so every entry is loaded before the
   // first pixel. Palette loads carry random upper address bits, which must be ignored.
   task automatic test_load_tables();
      for (int i = 0; i < (1 << ped_pkg::NEAR_AW); i++)
         send_load(ped_pkg::ACT_NEAR, 12'(i), 24'($urandom));
      for (int i = 0; i < (1 << ped_pkg::PAL_AW); i++)
         send_load(ped_pkg::ACT_PAL, {4'($urandom), 8'(i)}, 24'($urandom));
   endtask

   // Color dither on channel extremes over two short rows, so that large errors
   // push the sums past both ends of the clamp.
   task automatic test_rgb_dither_extremes();
      wait_idle();
      apply_mode(1'b1, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
   endtask

   // The unused action must vanish, a palette load must use only the low address
   // byte, and a fresh nearest-table entry must show up on the next pixel.
   task automatic test_table_actions();
      send_beat(ped_pkg::ACT_RSVD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 12'hFFF, 24'hFFFFFF);
      send_beat(ped_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 1'b0, 12'hF3C, 24'h00FF00);
      send_beat(ped_pkg::ACT_NEAR, 8'h00, 8'h00, 8'h00, 1'b0, 12'hFFF, 24'hFFFFFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
   endtask

   // Grey dither. Black maps to a white palette entry and white to a black one, so
   // the grey sum runs below zero and above full scale within one row.
   task automatic test_grey_dither();
      wait_idle();
      apply_mode(1'b1, 1'b1);
      send_beat(ped_pkg::ACT_NEAR, 8'h00, 8'h00, 8'h00, 1'b0, 12'h000, 24'h000001);
      send_beat(ped_pkg::ACT_NEAR, 8'h00, 8'h00, 8'h00, 1'b0, 12'hFFF, 24'hFFFF02);
      send_beat(ped_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 1'b0, 12'h001, 24'hFF0000);
      send_beat(ped_pkg::ACT_PAL, 8'h00, 8'h00, 8'h00, 1'b0, 12'hA02, 24'h000000);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
      send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
   endtask

   // Plain lookup in both color and grey modes; the column still advances.
   task automatic test_plain_lookup();
      wait_idle();
      apply_mode(1'b0, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      wait_idle();
      apply_mode(1'b0, 1'b1);
      send_pixel(8'hC8, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'h07, 8'h00, 8'hFF, 1'b0);
   endtask

   // One dithered row longer than the error line: the column wraps back to zero
   // and the last column's spill entry is exercised.
   task automatic test_overlong_row();
      wait_idle();
      apply_mode(1'b1, 1'b0);
      send_idle_pct = 0;
      stall_pct    <= 0;
      for (int i = 0; i < ped_pkg::MAX_WIDTH + 4; i++)
         send_pixel(pick_channel(), pick_channel(), pick_channel(), i == 0);
      send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b1);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // dithered pixels, so the queue fills and the block must stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct    <= 0;
      hold_left    <= 400;
      repeat (40) send_pixel(pick_channel(), pick_channel(), pick_channel(),
                             $urandom_range(0, 15) == 0);
   endtask

   task automatic send_random_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         send_pixel(pick_channel(), pick_channel(), pick_channel(),
                    $urandom_range(0, 24) == 0);
      else if (pick < 88)
         send_load(ped_pkg::ACT_NEAR, 12'($urandom), 24'($urandom));
      else if (pick < 96)
         send_load(ped_pkg::ACT_PAL, 12'($urandom), 24'($urandom));
      else
         send_load(ped_pkg::ACT_RSVD, 12'($urandom), 24'($urandom));
   endtask

   // Random traffic in eight phases: each mode setting runs twice, and the four
   // idling patterns take two phases each. Rows have random lengths, and table
   // loads land in the middle of them.
   task automatic test_random_phases();
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         apply_mode((p & 2) == 0, (p & 1) != 0);
         case (p / 2)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
            end
            1: begin
               send_idle_pct = 58;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 58;
            end
            default: begin
               send_idle_pct = 26;
               stall_pct    <= 26;
            end
         endcase
         repeat (PHASE_BEATS) send_random_beat();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // The block clears its error lines after reset; send_beat simply waits on tready.
      test_load_tables();
      test_rgb_dither_extremes();
      test_table_actions();
      test_grey_dither();
      test_plain_lookup();
      test_overlong_row();
      test_backpressure();
      test_random_phases();
      wait_idle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
